// ----- src/stdc_pkg.sv -----
// Shared types, codes and constants for the setpoint and temperature display controller.
// Used by the top level and by the port checker; depends on nothing else.
package stdc_pkg;

  // Field widths of the input and result items.
  localparam int unsigned TEMP_W   = 10;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned BRIGHT_W = 3;
  localparam int unsigned HOLD_W   = 16;
  localparam int unsigned HALF_W   = 15;
  localparam int unsigned BLINK_W  = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned QUOT_W   = 7;
  localparam int unsigned TOPQ_W   = 4;

  // Display codes.
  localparam logic [DIGIT_W-1:0]  BLANK_CODE    = 4'd15;
  localparam logic [BRIGHT_W-1:0] BRIGHT_NORMAL = 3'd2;
  localparam logic [BRIGHT_W-1:0] BRIGHT_MAX    = 3'd7;

  // Register values after reset.
  localparam logic [HOLD_W-1:0] HOLD_TIME_RST  = 16'd2000;
  localparam logic [HALF_W-1:0] BLINK_HALF_RST = 15'd500;

  // Kind of an input item.
  typedef enum logic {
    KIND_TICK   = 1'b0,
    KIND_UPDATE = 1'b1
  } kind_t;

  // Configuration register indexes.
  typedef enum logic {
    CFG_HOLD_TIME  = 1'b0,
    CFG_BLINK_HALF = 1'b1
  } cfg_index_t;

  // Quotient by ten for values up to 1023: multiply by 205/2048, exact in that range.
  function automatic logic [QUOT_W-1:0] div10(input logic [TEMP_W-1:0] v);
    logic [17:0] prod;
    prod = {8'd0, v} * 18'd205;
    return prod[17:11];
  endfunction

endpackage

// ----- src/setpoint_temperature_display_controller.sv -----
// Top level of the setpoint and temperature display controller.
// Depends on stdc_pkg for codes, widths and the divide-by-ten helper.

// The block takes one item in every clock cycle while in_stall is low. A tick
// item updates the hold and blink counters and yields no result; an update item
// yields one result: it updates the state and picks the shown value into the
// middle stage register, then the digit split puts its decimal digits into the
// output register. in_stall rises only when both pipeline stages hold items and
// the output is stalled. Configuration registers take effect on the next item.
module setpoint_temperature_display_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input items
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_kind,
  input  logic [stdc_pkg::TEMP_W-1:0]          in_temperature,
  input  logic [stdc_pkg::TEMP_W-1:0]          in_setpoint,
  // Result items
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [stdc_pkg::DIGIT_W-1:0]         out_hundreds_digit,
  output logic [stdc_pkg::DIGIT_W-1:0]         out_tens_digit,
  output logic [stdc_pkg::DIGIT_W-1:0]         out_units_digit,
  output logic                                 out_heat_point,
  output logic [stdc_pkg::BRIGHT_W-1:0]        out_brightness,
  output logic                                 out_shows_setpoint,
  // Configuration writes
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [stdc_pkg::CFG_W-1:0]           cfg_wdata
);
  import stdc_pkg::*;

  // Configuration registers.
  logic [HOLD_W-1:0]   hold_time_r;
  logic [HALF_W-1:0]   blink_half_r;

  // Block state.
  logic [TEMP_W-1:0]   last_setpoint_r, last_setpoint_nxt;
  logic [HOLD_W-1:0]   hold_cnt_r, hold_cnt_nxt;
  logic [BLINK_W-1:0]  blink_cnt_r, blink_cnt_nxt;
  logic [BRIGHT_W-1:0] bright_r, bright_nxt;

  // Middle stage: chosen value and flags.
  logic                mid_valid_r, mid_valid_nxt;
  logic [TEMP_W-1:0]   mid_value_r, mid_value_nxt;
  logic                mid_point_r, mid_point_nxt;
  logic                mid_show_sp_r, mid_show_sp_nxt;

  // Output stage.
  logic                out_valid_r;
  logic [DIGIT_W-1:0]  out_h_r, out_t_r, out_u_r;
  logic                out_point_r, out_show_sp_r;
  logic [BRIGHT_W-1:0] out_bright_r;

  // Flow control.
  logic out_adv, mid_adv, accept;
  logic is_update;

  // Counter helpers.
  logic [HALF_W-1:0]  half;
  logic [BLINK_W:0]   period;
  logic [BLINK_W:0]   blink_inc;

  // Digit split.
  logic [QUOT_W-1:0]  q1;
  logic [TOPQ_W-1:0]  q2;
  logic [TEMP_W-1:0]  u_rem;
  logic [QUOT_W-1:0]  t_rem;
  logic [DIGIT_W-1:0] u_dig, t_dig, h_dig;

  logic               changed;

  // Each stage moves when the stage after it is empty or moving.
  assign out_adv   = !out_valid_r || !out_stall;
  assign mid_adv   = !mid_valid_r || out_adv;
  assign in_stall  = !mid_adv;
  assign accept    = in_valid && !in_stall;
  assign is_update = (in_kind == KIND_UPDATE);

  // Half period, with zero read as one.
  assign half      = (blink_half_r == '0) ? HALF_W'(1) : blink_half_r;
  assign period    = {1'b0, half, 1'b0};
  assign blink_inc = {1'b0, blink_cnt_r} + (BLINK_W+1)'(1);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_time_r  <= HOLD_TIME_RST;
      blink_half_r <= BLINK_HALF_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_HOLD_TIME:  hold_time_r  <= cfg_wdata;
        CFG_BLINK_HALF: blink_half_r <= cfg_wdata[HALF_W-1:0];
        default:        ;
      endcase
    end
  end

  // State update and value selection for the accepted item.
  always_comb begin
    last_setpoint_nxt = last_setpoint_r;
    hold_cnt_nxt      = hold_cnt_r;
    blink_cnt_nxt     = blink_cnt_r;
    bright_nxt        = bright_r;
    mid_value_nxt     = in_temperature;
    mid_show_sp_nxt   = 1'b0;
    mid_point_nxt     = (in_temperature < in_setpoint) &&
                        (blink_cnt_r >= {1'b0, half});
    changed           = (in_setpoint != last_setpoint_r);
    if (accept) begin
      if (!is_update) begin
        if (hold_cnt_r != '0) begin
          hold_cnt_nxt = hold_cnt_r - HOLD_W'(1);
        end
        blink_cnt_nxt = (blink_inc >= period) ? '0 : blink_inc[BLINK_W-1:0];
      end else begin
        if (changed) begin
          last_setpoint_nxt = in_setpoint;
          hold_cnt_nxt      = hold_time_r;
          bright_nxt        = BRIGHT_MAX;
        end
        if (hold_cnt_nxt != '0) begin
          mid_value_nxt   = in_setpoint;
          mid_show_sp_nxt = 1'b1;
        end else begin
          bright_nxt = BRIGHT_NORMAL;
        end
      end
    end
    mid_valid_nxt = accept && is_update;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_setpoint_r <= '0;
      hold_cnt_r      <= '0;
      blink_cnt_r     <= '0;
      bright_r        <= BRIGHT_NORMAL;
    end else begin
      last_setpoint_r <= last_setpoint_nxt;
      hold_cnt_r      <= hold_cnt_nxt;
      blink_cnt_r     <= blink_cnt_nxt;
      bright_r        <= bright_nxt;
    end
  end

  // Middle stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
    end else if (mid_adv) begin
      mid_valid_r <= mid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_adv) begin
      mid_value_r   <= mid_value_nxt;
      mid_point_r   <= mid_point_nxt;
      mid_show_sp_r <= mid_show_sp_nxt;
    end
  end

  // Digit split, units first; a position is blank once its quotient is zero.
  always_comb begin
    q1    = div10(mid_value_r);
    q2    = TOPQ_W'(div10({3'd0, q1}));
    u_rem = mid_value_r - TEMP_W'({3'd0, q1} * 10'd10);
    t_rem = q1 - QUOT_W'({3'd0, q2} * 7'd10);
    u_dig = (mid_value_r != '0) ? u_rem[DIGIT_W-1:0] : BLANK_CODE;
    t_dig = (q1 != '0) ? t_rem[DIGIT_W-1:0] : BLANK_CODE;
    if (q2 == '0) begin
      h_dig = BLANK_CODE;
    end else if (q2 == TOPQ_W'(10)) begin
      h_dig = '0;
    end else begin
      h_dig = q2;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= mid_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && mid_valid_r) begin
      out_h_r       <= h_dig;
      out_t_r       <= t_dig;
      out_u_r       <= u_dig;
      out_point_r   <= mid_point_r;
      out_show_sp_r <= mid_show_sp_r;
      out_bright_r  <= bright_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hundreds_digit = out_h_r;
  assign out_tens_digit     = out_t_r;
  assign out_units_digit    = out_u_r;
  assign out_heat_point     = out_point_r;
  assign out_brightness     = out_bright_r;
  assign out_shows_setpoint = out_show_sp_r;

endmodule

// ----- src/stdc_checker.sv -----
// Port-level checker for the setpoint and temperature display controller, with its bind.
// Depends on stdc_pkg for widths and display codes.
module stdc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [stdc_pkg::DIGIT_W-1:0]  out_hundreds_digit,
  input logic [stdc_pkg::DIGIT_W-1:0]  out_tens_digit,
  input logic [stdc_pkg::DIGIT_W-1:0]  out_units_digit,
  input logic [stdc_pkg::BRIGHT_W-1:0] out_brightness,
  input logic                          out_shows_setpoint
);
  import stdc_pkg::*;

  // A stalled item keeps its digits.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hundreds_digit) &&
      $stable(out_tens_digit) && $stable(out_units_digit))
    else $error("stalled result item changed");

  // The temperature screen is always at typical brightness.
  a_temp_bright: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_shows_setpoint |-> out_brightness == BRIGHT_NORMAL)
    else $error("temperature shown at wrong brightness");

  // The setpoint screen is always at full brightness.
  a_sp_bright: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_shows_setpoint |-> out_brightness == BRIGHT_MAX)
    else $error("setpoint shown at wrong brightness");

  // Blanking runs from the left: a shown hundreds digit has shown tens and units digits.
  a_blank_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hundreds_digit != BLANK_CODE |->
      out_tens_digit != BLANK_CODE && out_units_digit != BLANK_CODE)
    else $error("digit shown left of a blank position");

endmodule

bind setpoint_temperature_display_controller stdc_checker u_stdc_checker (.*);
